// File: hw/rtl/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern scanner
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

   localparam int MAX_PATTERN_BYTES = 32;
   localparam int ADDRESS_BITS      = 48;
   localparam int LENGTH_BITS       = 6;
   localparam int COUNT_BITS        = 20;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_ADDR_BITS     = 6;
   localparam int PATTERN_WORDS     = 4;

   localparam logic [COUNT_BITS-1:0]  DEFAULT_LIMIT  = COUNT_BITS'(500000);
   localparam logic [LENGTH_BITS-1:0] DEFAULT_LENGTH = LENGTH_BITS'(1);

   typedef enum logic [2:0] {
      REG_PATTERN_LOW    = 3'd0,
      REG_PATTERN_SECOND = 3'd1,
      REG_PATTERN_THIRD  = 3'd2,
      REG_PATTERN_HIGH   = 3'd3,
      REG_PATTERN_LENGTH = 3'd4,
      REG_WILDCARD_EN    = 3'd5,
      REG_WILDCARD_BYTE  = 3'd6,
      REG_RESULT_LIMIT   = 3'd7
   } reg_index_type;

   // derived settings, ready for the compare and the match counter
   typedef struct packed {
      logic [MAX_PATTERN_BYTES-1:0][7:0] aligned;  // aligned[j] meets the byte j places back
      logic [MAX_PATTERN_BYTES-1:0]      care;
      logic [LENGTH_BITS-1:0]            length;
      logic [COUNT_BITS-1:0]             limit;
   } cfg_type;

   // window stage towards the match counter
   typedef struct packed {
      logic                    valid;
      logic                    hit;
      logic [ADDRESS_BITS-1:0] match_address;
   } stage_type;

endpackage

`default_nettype wire

// File: hw/rtl/wbps_csr.sv
// register file with derived pattern alignment and care mask
`timescale 1ns / 1ps
`default_nettype none

module wbps_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [wbps_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire  [wbps_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wbps_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output wbps_pkg::cfg_type                    cfg
);

   logic [wbps_pkg::PATTERN_WORDS-1:0][wbps_pkg::CSR_DATA_BITS-1:0] pattern_ff, pattern_in;
   logic [wbps_pkg::LENGTH_BITS-1:0] length_ff, length_in;
   logic                             wc_en_ff, wc_en_in;
   logic [7:0]                       wc_byte_ff, wc_byte_in;
   logic [wbps_pkg::COUNT_BITS-1:0]  limit_ff, limit_in;
   wbps_pkg::cfg_type                cfg_ff, cfg_in;

   logic [wbps_pkg::MAX_PATTERN_BYTES-1:0][7:0] pattern_bytes;
   logic [wbps_pkg::LENGTH_BITS-1:0]            eff_length;
   wbps_pkg::reg_index_type                     index;
   logic                                        write_en;

   assign pattern_bytes = pattern_ff;
   assign index         = wbps_pkg::reg_index_type'(csr_paddr[5:3]);
   assign write_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready    = 1'b1;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      wc_en_in   = wc_en_ff;
      wc_byte_in = wc_byte_ff;
      limit_in   = limit_ff;
      if (write_en) begin
         case (index)
            wbps_pkg::REG_PATTERN_LOW:    pattern_in[0] = csr_pwdata;
            wbps_pkg::REG_PATTERN_SECOND: pattern_in[1] = csr_pwdata;
            wbps_pkg::REG_PATTERN_THIRD:  pattern_in[2] = csr_pwdata;
            wbps_pkg::REG_PATTERN_HIGH:   pattern_in[3] = csr_pwdata;
            wbps_pkg::REG_PATTERN_LENGTH: length_in = csr_pwdata[wbps_pkg::LENGTH_BITS-1:0];
            wbps_pkg::REG_WILDCARD_EN:    wc_en_in = csr_pwdata[0];
            wbps_pkg::REG_WILDCARD_BYTE:  wc_byte_in = csr_pwdata[7:0];
            wbps_pkg::REG_RESULT_LIMIT:   limit_in = csr_pwdata[wbps_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (index)
         wbps_pkg::REG_PATTERN_LOW:    csr_prdata = pattern_ff[0];
         wbps_pkg::REG_PATTERN_SECOND: csr_prdata = pattern_ff[1];
         wbps_pkg::REG_PATTERN_THIRD:  csr_prdata = pattern_ff[2];
         wbps_pkg::REG_PATTERN_HIGH:   csr_prdata = pattern_ff[3];
         wbps_pkg::REG_PATTERN_LENGTH:
            csr_prdata = wbps_pkg::CSR_DATA_BITS'(length_ff);
         wbps_pkg::REG_WILDCARD_EN:    csr_prdata = wbps_pkg::CSR_DATA_BITS'(wc_en_ff);
         wbps_pkg::REG_WILDCARD_BYTE:  csr_prdata = wbps_pkg::CSR_DATA_BITS'(wc_byte_ff);
         wbps_pkg::REG_RESULT_LIMIT:   csr_prdata = wbps_pkg::CSR_DATA_BITS'(limit_ff);
         default: csr_prdata = '0;
      endcase
   end

   // zero length acts as one, anything past the window acts as full width
   always_comb begin
      if (length_ff == '0) begin
         eff_length = wbps_pkg::LENGTH_BITS'(1);
      end else if (length_ff > wbps_pkg::LENGTH_BITS'(wbps_pkg::MAX_PATTERN_BYTES)) begin
         eff_length = wbps_pkg::LENGTH_BITS'(wbps_pkg::MAX_PATTERN_BYTES);
      end else begin
         eff_length = length_ff;
      end
   end

   // pattern byte length-1-j is compared with the byte j places behind the newest
   always_comb begin
      logic [wbps_pkg::LENGTH_BITS-1:0] pos;
      cfg_in.length = eff_length;
      cfg_in.limit  = (limit_ff == '0) ? wbps_pkg::COUNT_BITS'(1) : limit_ff;
      for (int j = 0; j < wbps_pkg::MAX_PATTERN_BYTES; j++) begin
         pos = eff_length - wbps_pkg::LENGTH_BITS'(1) - wbps_pkg::LENGTH_BITS'(j);
         cfg_in.aligned[j] = pattern_bytes[pos[4:0]];
         cfg_in.care[j]    = (wbps_pkg::LENGTH_BITS'(j) < eff_length) &&
                             !(wc_en_ff && (pattern_bytes[pos[4:0]] == wc_byte_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= wbps_pkg::DEFAULT_LENGTH;
         wc_en_ff   <= 1'b0;
         wc_byte_ff <= '0;
         limit_ff   <= wbps_pkg::DEFAULT_LIMIT;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
         wc_en_ff   <= wc_en_in;
         wc_byte_ff <= wc_byte_in;
         limit_ff   <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/wbps_window.sv
// input register stage: byte window, fill count and parallel compare
`timescale 1ns / 1ps
`default_nettype none

module wbps_window (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [7:0]                          data_byte,
   input  wire  [wbps_pkg::ADDRESS_BITS-1:0]   byte_address,
   input  wire                                 region_start,
   input  wire                                 advance,
   input  wbps_pkg::cfg_type                   cfg,
   output wbps_pkg::stage_type                 stage
);

   logic [wbps_pkg::MAX_PATTERN_BYTES-1:0][7:0] window_ff, window_in;
   logic [wbps_pkg::LENGTH_BITS-1:0]            fill_ff, fill_in;
   logic                                        valid_ff, valid_in;
   logic [wbps_pkg::ADDRESS_BITS-1:0]           addr_ff, addr_in;
   logic [wbps_pkg::MAX_PATTERN_BYTES-1:0]      byte_ok;
   logic                                        accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      addr_in   = addr_ff;
      valid_in  = valid_ff && !advance;
      if (accept) begin
         valid_in  = 1'b1;
         window_in = {window_ff[wbps_pkg::MAX_PATTERN_BYTES-2:0], data_byte};
         addr_in   = byte_address -
                     wbps_pkg::ADDRESS_BITS'(cfg.length - wbps_pkg::LENGTH_BITS'(1));
         // a new region restarts the fill count at this byte, so older bytes never match
         if (region_start) begin
            fill_in = wbps_pkg::LENGTH_BITS'(1);
         end else if (fill_ff != wbps_pkg::LENGTH_BITS'(wbps_pkg::MAX_PATTERN_BYTES)) begin
            fill_in = fill_ff + wbps_pkg::LENGTH_BITS'(1);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < wbps_pkg::MAX_PATTERN_BYTES; j++) begin
         byte_ok[j] = !cfg.care[j] || (window_ff[j] == cfg.aligned[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         fill_ff   <= '0;
         window_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         fill_ff   <= fill_in;
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign stage.valid         = valid_ff;
   assign stage.hit           = (&byte_ok) && (fill_ff >= cfg.length);
   assign stage.match_address = addr_ff;

endmodule

`default_nettype wire

// File: hw/rtl/wbps_counter.sv
// match counter, cap flag and result register
`timescale 1ns / 1ps
`default_nettype none

module wbps_counter (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wbps_pkg::stage_type                 stage,
   input  wbps_pkg::cfg_type                   cfg,
   output logic                                advance,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [wbps_pkg::ADDRESS_BITS-1:0]   match_address,
   output logic [wbps_pkg::COUNT_BITS-1:0]     match_number,
   output logic                                limit_reached
);

   logic                            out_valid_ff, out_valid_in;
   logic [wbps_pkg::COUNT_BITS-1:0] total_ff, total_in;
   logic                            capped_ff, capped_in;
   logic [wbps_pkg::ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [wbps_pkg::COUNT_BITS-1:0] number_ff, number_in;
   logic                            reached_ff, reached_in;
   logic [wbps_pkg::COUNT_BITS-1:0] total_next;
   logic                            take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign take       = stage.valid && advance && stage.hit && !capped_ff;
   assign total_next = total_ff + wbps_pkg::COUNT_BITS'(1);

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      total_in     = total_ff;
      capped_in    = capped_ff;
      addr_in      = addr_ff;
      number_in    = number_ff;
      reached_in   = reached_ff;
      if (take) begin
         // limit lowered to or below the count: swallow the match and cap
         if (total_ff >= cfg.limit) begin
            capped_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
            total_in     = total_next;
            capped_in    = (total_next >= cfg.limit);
            addr_in      = stage.match_address;
            number_in    = total_next;
            reached_in   = (total_next >= cfg.limit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
         capped_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         total_ff     <= total_in;
         capped_ff    <= capped_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      number_ff  <= number_in;
      reached_ff <= reached_in;
   end

   assign rsp_tvalid    = out_valid_ff;
   assign match_address = addr_ff;
   assign match_number  = number_ff;
   assign limit_reached = reached_ff;

endmodule

`default_nettype wire

// File: hw/rtl/wildcard_byte_pattern_scanner.sv
// top level of the wildcard byte pattern scanner
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | data_byte, byte_address, region_start
//   rsp     | out       | rsp_tvalid/rsp_tready | match_address, match_number, limit_reached
//   csr     | in/out    | psel/penable, pready  | 64-bit registers at 8-byte steps
//
// one byte per cycle sustained unless rsp stalls; each transaction passes the window
// register, whose 32 parallel byte compares feed the result register directly.
// a match reaches rsp through the window register and then the result register.
// synchronous reset clears the window, fill count, match total and cap flag.
// a stalled rsp holds the window stage, so req backs up only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [55:0]  req_tdata,   // data_byte [7:0], byte_address [55:8]
   input  wire          req_tuser,   // region_start
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [71:0]  rsp_tdata,   // match_address [47:0], match_number [67:48], zero pad
   output logic         rsp_tuser,   // limit_reached
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [5:0]   csr_paddr,
   input  wire  [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   wbps_pkg::cfg_type                 cfg;
   wbps_pkg::stage_type               stage;
   logic                              advance;
   logic [wbps_pkg::ADDRESS_BITS-1:0] match_address;
   logic [wbps_pkg::COUNT_BITS-1:0]   match_number;

   wbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wbps_window u_window (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .data_byte    (req_tdata[7:0]),
      .byte_address (req_tdata[55:8]),
      .region_start (req_tuser),
      .advance      (advance),
      .cfg          (cfg),
      .stage        (stage)
   );

   wbps_counter u_counter (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .cfg           (cfg),
      .advance       (advance),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .match_address (match_address),
      .match_number  (match_number),
      .limit_reached (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, match_number, match_address};

endmodule

`default_nettype wire
